@@ hw/rtl/drra_pkg.sv @@
// Shared constants for the damped range ratio average block.
package drra_pkg;

  // Fixed field widths
  localparam int WORD_W      = 32;
  localparam int DAMP_W      = 17;
  localparam int PERIOD_W    = 9;
  localparam int SUM_W       = 40;
  localparam int SEEN_W      = 9;

  // Defaults for the top-level parameters
  localparam int MAX_PERIOD_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // Register reset values
  localparam logic [DAMP_W-1:0]   DAMPING_RST = 17'd7;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 9'd2;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_DAMPING = 1'b0;
  localparam logic REG_PERIOD  = 1'b1;

  // Saturation limits
  localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

  // Counter ceiling
  localparam logic [SEEN_W-1:0] SEEN_MAX = 9'd511;

endpackage

@@ hw/rtl/drra_if.sv @@
// Valid/ready channel interfaces for bar items and result items.
interface drra_bar_if import drra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bar_high;
  logic [WORD_W-1:0] bar_low;
  logic [WORD_W-1:0] bar_close;
  logic signed [WORD_W-1:0] series_sample;
  logic              bar_start;

  modport source (output valid, bar_high, bar_low, bar_close, series_sample, bar_start,
                  input ready);
  modport sink   (input valid, bar_high, bar_low, bar_close, series_sample, bar_start,
                  output ready);
endinterface

interface drra_res_if import drra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [WORD_W-1:0] average;
  logic              valid_res;

  modport source (output valid, average, valid_res, input ready);
  modport sink   (input valid, average, valid_res, output ready);
endinterface

@@ hw/rtl/damped_range_ratio_average_top.sv @@
// Damped range ratio average: sequencer around one shared radix-4 divider.
// Each item takes up to three divisions in turn on the one divider (ratio, term, mean),
// two quotient bits a cycle; a division is skipped when its operands call for a constant.
// A new item is taken only once the last one is through, but while its result waits.
// Reset (rst, synchronous, active high) clears registers, ring pointer, sum and count;
// the term ring is not cleared, so no clearing pass follows reset.
module damped_range_ratio_average_top import drra_pkg::*; #(
  parameter int MAX_PERIOD = MAX_PERIOD_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  drra_bar_if.sink              bar,
  drra_res_if.source            result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]     pwdata,
  output logic [WORD_W-1:0]     prdata,
  output logic                  pready
);

  localparam int PTR_W   = $clog2(MAX_PERIOD);
  localparam int PW      = $clog2(MAX_PERIOD + 1);
  localparam int CW      = ((PW > PERIOD_W) ? PW : PERIOD_W) + 1;
  localparam int IW      = CW + 1;
  localparam int DVD_W0  = ((WORD_W + FRAC_BITS) > SUM_W) ? (WORD_W + FRAC_BITS) : SUM_W;
  localparam int DVD_W   = DVD_W0 + (DVD_W0 % 2);
  localparam int DSR_W   = WORD_W;
  localparam int STEPS   = DVD_W / 2;
  localparam int CNT_W   = $clog2(STEPS + 1);
  localparam logic [WORD_W-1:0] SMALL_CLOSE = WORD_W'(((1 << FRAC_BITS) + 50) / 100);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RDIV, S_REND, S_TPREP, S_TDIV, S_TEND,
    S_ADD, S_SUB, S_APREP, S_ADIV, S_AEND, S_OUT
  } state_t;

  state_t state;

  // Configuration
  logic [DAMP_W-1:0]   damping;
  logic [PERIOD_W-1:0] period;

  // Block state
  logic [WORD_W-1:0] previous_close;
  logic [PTR_W-1:0]  ring_pointer;
  logic [SUM_W-1:0]  window_sum;
  logic [SEEN_W-1:0] bars_seen;

  // Latched item and intermediate values
  logic [WORD_W-1:0]        hi, lo, cl;
  logic signed [WORD_W-1:0] series;
  logic signed [WORD_W-1:0] ratio, term, avg;
  logic                     leave;
  logic                     valid_now;
  logic [WORD_W-1:0]        rd_data;

  // Shared divider
  logic [DSR_W:0]   rem;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic             dneg;
  logic [CNT_W-1:0] cnt;

  // Output register
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_average;
  logic                     out_valid_res;

  // Memory
  logic [WORD_W-1:0] ring [MAX_PERIOD];

  // One restoring division step
  function automatic logic [DSR_W+DVD_W:0] div_step(input logic [DSR_W:0] r,
                                                    input logic [DVD_W-1:0] d,
                                                    input logic [DSR_W-1:0] s);
    logic [DSR_W:0]   sh;
    logic [DSR_W:0]   tr;
    logic [DVD_W-1:0] dn;
    sh = {r[DSR_W-1:0], d[DVD_W-1]};
    tr = sh - {1'b0, s};
    if (!tr[DSR_W]) begin
      sh = tr;
      dn = {d[DVD_W-2:0], 1'b1};
    end else begin
      dn = {d[DVD_W-2:0], 1'b0};
    end
    return {sh, dn};
  endfunction

  // Apply sign to a quotient magnitude and clamp to 32-bit signed
  function automatic logic [WORD_W-1:0] sat_q(input logic [DVD_W-1:0] m, input logic n);
    logic [DVD_W-1:0] lim;
    logic [WORD_W-1:0] res;
    lim = {{(DVD_W-WORD_W){1'b0}}, S32_MIN};
    if (n) begin
      res = (m > lim) ? S32_MIN : (~m[WORD_W-1:0] + 1'b1);
    end else begin
      res = (m >= lim) ? S32_MAX : m[WORD_W-1:0];
    end
    return res;
  endfunction

  // Combinational helpers
  logic [DSR_W+DVD_W:0] step1, step2;
  logic [CW-1:0]        per_ext, p_eff, seen_ext;
  logic [IW-1:0]        idx_w;
  logic [PTR_W-1:0]     rd_idx;
  logic [WORD_W:0]      diff;
  logic [WORD_W-1:0]    diff_mag;
  logic [WORD_W+1:0]    den;
  logic [WORD_W+1:0]    den_neg;
  logic [WORD_W-1:0]    ratio_mag;
  logic [SUM_W-1:0]     sum_mag;
  logic [SUM_W-1:0]     sum_add, sum_sub;
  logic                 bar_acc, out_free;

  always_comb begin
    step1 = div_step(rem, dvd, dsr);
    step2 = div_step(step1[DSR_W+DVD_W:DVD_W], step1[DVD_W-1:0], dsr);
  end

  // Effective period and the index of the leaving term
  always_comb begin
    per_ext = CW'(period);
    if (per_ext < CW'(2)) begin
      p_eff = CW'(2);
    end else if (per_ext > CW'(MAX_PERIOD)) begin
      p_eff = CW'(MAX_PERIOD);
    end else begin
      p_eff = per_ext;
    end
    seen_ext = CW'(bars_seen);
    if (IW'(ring_pointer) >= IW'(p_eff)) begin
      idx_w = IW'(ring_pointer) - IW'(p_eff);
    end else begin
      idx_w = IW'(ring_pointer) + IW'(MAX_PERIOD) - IW'(p_eff);
    end
    rd_idx = idx_w[PTR_W-1:0];
  end

  // Operand magnitudes
  always_comb begin
    diff      = {1'b0, hi} - {1'b0, lo};
    diff_mag  = diff[WORD_W] ? (~diff[WORD_W-1:0] + 1'b1) : diff[WORD_W-1:0];
    den       = {{2{series[WORD_W-1]}}, series} + (WORD_W+2)'(damping);
    den_neg   = ~den + 1'b1;
    ratio_mag = ratio[WORD_W-1] ? (~ratio + 1'b1) : ratio;
    sum_mag   = window_sum[SUM_W-1] ? (~window_sum + 1'b1) : window_sum;
    sum_add   = window_sum + {{(SUM_W-WORD_W){term[WORD_W-1]}}, term};
    sum_sub   = window_sum - {{(SUM_W-WORD_W){rd_data[WORD_W-1]}}, rd_data};
  end

  assign bar_acc  = bar.valid && bar.ready;
  assign out_free = !out_valid || result.ready;

  // Channel ports
  assign bar.ready        = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.average   = out_average;
  assign result.valid_res = out_valid_res;

  // Configuration read side
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_DAMPING: prdata = {{(WORD_W-DAMP_W){1'b0}}, damping};
      REG_PERIOD:  prdata = {{(WORD_W-PERIOD_W){1'b0}}, period};
      default:     prdata = '0;
    endcase
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      damping        <= DAMPING_RST;
      period         <= PERIOD_RST;
      previous_close <= '0;
      ring_pointer   <= '0;
      window_sum     <= '0;
      bars_seen      <= '0;
      out_valid      <= 1'b0;
      out_average    <= '0;
      out_valid_res  <= 1'b0;
      hi <= '0; lo <= '0; cl <= '0; series <= '0;
      ratio <= '0; term <= '0; avg <= '0;
      leave <= 1'b0; valid_now <= 1'b0;
      rem <= '0; dvd <= '0; dsr <= '0; dneg <= 1'b0; cnt <= '0;
    end else begin
      // Register writes
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_DAMPING: damping <= pwdata[DAMP_W-1:0];
          REG_PERIOD:  period  <= pwdata[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it
      if (out_valid && result.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (bar_acc) begin
            hi     <= bar.bar_high;
            lo     <= bar.bar_low;
            cl     <= bar.bar_close;
            series <= bar.series_sample;
            if (bar.bar_start) begin
              window_sum <= '0;
              bars_seen  <= '0;
            end
            state <= S_PREP;
          end
        end

        // Start the ratio division, or use the small-close constant
        S_PREP: begin
          leave <= (seen_ext >= p_eff);
          if (previous_close > SMALL_CLOSE) begin
            rem   <= '0;
            dvd   <= {{(DVD_W-WORD_W){1'b0}}, diff_mag} << FRAC_BITS;
            dsr   <= previous_close;
            dneg  <= diff[WORD_W];
            cnt   <= CNT_W'(STEPS);
            state <= S_RDIV;
          end else begin
            ratio <= SMALL_CLOSE;
            state <= S_TPREP;
          end
        end

        S_RDIV, S_TDIV, S_ADIV: begin
          rem <= step2[DSR_W+DVD_W:DVD_W];
          dvd <= step2[DVD_W-1:0];
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            unique case (state)
              S_RDIV:  state <= S_REND;
              S_TDIV:  state <= S_TEND;
              default: state <= S_AEND;
            endcase
          end
        end

        S_REND: begin
          ratio <= sat_q(dvd, dneg);
          state <= S_TPREP;
        end

        // Start the term division, or saturate on a zero denominator
        S_TPREP: begin
          if (den == '0) begin
            if (ratio == '0) begin
              term <= '0;
            end else begin
              term <= ratio[WORD_W-1] ? S32_MIN : S32_MAX;
            end
            state <= S_ADD;
          end else begin
            rem   <= '0;
            dvd   <= {{(DVD_W-WORD_W){1'b0}}, ratio_mag} << FRAC_BITS;
            dsr   <= den[WORD_W+1] ? den_neg[WORD_W-1:0] : den[WORD_W-1:0];
            dneg  <= ratio[WORD_W-1] ^ den[WORD_W+1];
            cnt   <= CNT_W'(STEPS);
            state <= S_TDIV;
          end
        end

        S_TEND: begin
          term  <= sat_q(dvd, dneg);
          state <= S_ADD;
        end

        // Add the new term and advance the ring
        S_ADD: begin
          window_sum <= sum_add;
          if (ring_pointer == PTR_W'(MAX_PERIOD - 1)) begin
            ring_pointer <= '0;
          end else begin
            ring_pointer <= ring_pointer + 1'b1;
          end
          state <= S_SUB;
        end

        // Remove the leaving term and count the bar
        S_SUB: begin
          if (leave) begin
            window_sum <= sum_sub;
          end
          if (bars_seen != SEEN_MAX) begin
            bars_seen <= bars_seen + 1'b1;
          end
          previous_close <= cl;
          state <= S_APREP;
        end

        // Start the mean division once the window is full
        S_APREP: begin
          valid_now <= (seen_ext >= p_eff + 1'b1);
          if (seen_ext >= p_eff + 1'b1) begin
            rem   <= '0;
            dvd   <= {{(DVD_W-SUM_W){1'b0}}, sum_mag};
            dsr   <= DSR_W'(p_eff);
            dneg  <= window_sum[SUM_W-1];
            cnt   <= CNT_W'(STEPS);
            state <= S_ADIV;
          end else begin
            avg   <= '0;
            state <= S_OUT;
          end
        end

        S_AEND: begin
          avg   <= sat_q(dvd, dneg);
          state <= S_OUT;
        end

        // Hold until the output register is free
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_average   <= avg;
            out_valid_res <= valid_now;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Term ring write
  always_ff @(posedge clk) begin
    if (state == S_ADD) begin
      ring[ring_pointer] <= term;
    end
  end

  // Term ring read of the leaving entry
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      rd_data <= ring[rd_idx];
    end
  end

endmodule
